// ===== rtl/spq_pkg.sv =====
// shared types and codes of the stable priority queue
package spq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRIO_W = 8;

  // request codes
  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_DISP = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  // one stored queue entry
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

endpackage

// ===== rtl/spq_store.sv =====
// circular entry memory with logical-to-physical address mapping
module spq_store import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] head_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output entry_t                   rd_entry_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  entry_t                   wr_entry_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  entry_t mem_q [DEPTH];
  entry_t rd_entry_q;

  // logical position to physical slot, one wrap at most
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[phys(head_i, wr_idx_i)] <= wr_entry_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q <= mem_q[phys(head_i, rd_idx_i)];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

// ===== rtl/stable_priority_queue_top.sv =====
// stable priority queue: sorted circular store under a small sequencer
//
// Entries are kept in priority order (smaller number first, ties in arrival
// order) in one memory with a single write and a single registered read
// port; that port pair sets the timing. An item is taken when start is high
// and busy is low. Enqueue into an empty or full queue answers straight from
// idle; otherwise it walks from the tail, reading each stored entry with a
// larger priority and moving it up one slot, then writes the new one. Dequeue
// reads the head and then hands it out, display streams the n entries head to
// tail, and an empty dequeue or display answers straight from idle.
// Results appear one per cycle, marked by valid_o for exactly one cycle, and
// cannot be held off by the receiver; last_o marks the final result of a
// transaction. Request code 3 is accepted and produces nothing.
module stable_priority_queue_top import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  input  logic [PRIO_W-1:0]        priority_in_i,
  output logic                     valid_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [PRIO_W-1:0]        priority_out_o,
  output logic                     last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_DEQ,
    S_DISP
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  entry_t new_q, new_d;

  logic valid_q, valid_d;
  logic [1:0] status_q, status_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic last_q, last_d;

  logic rd_en, wr_en;
  logic [AW-1:0] rd_idx, wr_idx;
  entry_t wr_entry, rd_entry;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_idx;
  logic is_full, is_empty;

  assign cnt_m1   = count_q - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  spq_store #(.DEPTH(DEPTH)) u_store (
    .clk_i      (clk_i),
    .head_i     (head_q),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry)
  );

  // sequencer next state, memory control and result
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    head_d   = head_q;
    count_d  = count_q;
    new_d    = new_q;
    valid_d  = 1'b0;
    status_d = STAT_OK;
    data_d   = '0;
    prio_d   = '0;
    last_d   = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = idx_q;
    wr_en    = 1'b0;
    wr_idx   = idx_q;
    wr_entry = new_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_type_i)
            REQ_ENQ: begin
              if (is_full) begin
                valid_d  = 1'b1;
                status_d = STAT_FULL;
                last_d   = 1'b1;
              end else if (is_empty) begin
                wr_en    = 1'b1;
                wr_idx   = '0;
                wr_entry = '{value: data_in_i, prio: priority_in_i};
                count_d  = count_q + CW'(1);
                valid_d  = 1'b1;
                last_d   = 1'b1;
              end else begin
                new_d   = '{value: data_in_i, prio: priority_in_i};
                rd_en   = 1'b1;
                rd_idx  = last_idx;
                idx_d   = last_idx;
                state_d = S_INS;
              end
            end
            REQ_DEQ: begin
              if (is_empty) begin
                valid_d  = 1'b1;
                status_d = STAT_UNDERFLOW;
                last_d   = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_idx  = '0;
                state_d = S_DEQ;
              end
            end
            REQ_DISP: begin
              if (is_empty) begin
                valid_d  = 1'b1;
                status_d = STAT_EMPTY;
                last_d   = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_idx  = '0;
                idx_d   = '0;
                state_d = S_DISP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // walk from the tail, moving larger priorities up one slot
      S_INS: begin
        wr_en  = 1'b1;
        wr_idx = idx_q + AW'(1);
        if (rd_entry.prio > new_q.prio) begin
          wr_entry = rd_entry;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d  = idx_q - AW'(1);
            rd_en  = 1'b1;
            rd_idx = idx_q - AW'(1);
          end
        end else begin
          wr_entry = new_q;
          count_d  = count_q + CW'(1);
          valid_d  = 1'b1;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // new entry goes to the head
      S_PUT: begin
        wr_en    = 1'b1;
        wr_idx   = '0;
        wr_entry = new_q;
        count_d  = count_q + CW'(1);
        valid_d  = 1'b1;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end

      // hand out the head and advance the head pointer
      S_DEQ: begin
        valid_d = 1'b1;
        data_d  = rd_entry.value;
        prio_d  = rd_entry.prio;
        last_d  = 1'b1;
        head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
        count_d = count_q - CW'(1);
        state_d = S_IDLE;
      end

      // stream entries head to tail
      S_DISP: begin
        valid_d = 1'b1;
        data_d  = rd_entry.value;
        prio_d  = rd_entry.prio;
        if (idx_q == last_idx) begin
          last_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d  = idx_q + AW'(1);
          rd_en  = 1'b1;
          rd_idx = idx_q + AW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      head_q   <= '0;
      count_q  <= '0;
      valid_q  <= 1'b0;
      new_q    <= '0;
      status_q <= STAT_OK;
      data_q   <= '0;
      prio_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      head_q   <= head_d;
      count_q  <= count_d;
      valid_q  <= valid_d;
      new_q    <= new_d;
      status_q <= status_d;
      data_q   <= data_d;
      prio_q   <= prio_d;
      last_q   <= last_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign data_out_o     = data_q;
  assign priority_out_o = prio_q;
  assign last_o         = last_q;

  // fill level never exceeds the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // final result of a transaction leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy)
    else $error("sequencer still busy after final result");

  // full status only when the queue really is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == STAT_FULL |-> count_q == CW'(DEPTH))
    else $error("full reported on a queue with room");

  // underflow only on an empty queue
  a_underflow_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == STAT_UNDERFLOW |-> count_q == '0)
    else $error("underflow reported on a non-empty queue");

  // unused request code makes no result
  a_none_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i == REQ_NONE |=> !valid_o)
    else $error("result produced for an unused request");

endmodule
